### src/oedm_pkg.sv
package oedm_pkg;

  localparam int DEF_DICT_DEPTH     = 1024;
  localparam int DEF_MAX_WORD_LEN   = 16;
  localparam int DEF_MAX_CANDIDATES = 63;

  localparam int OUT_IDX_W = 10;

  localparam logic [1:0] REQ_DICT  = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [2:0] VERDICT_CORRECT   = 3'd0;
  localparam logic [2:0] VERDICT_CANDIDATE = 3'd1;
  localparam logic [2:0] VERDICT_NONE      = 3'd2;
  localparam logic [2:0] VERDICT_TRUNC     = 3'd3;
  localparam logic [2:0] VERDICT_TOOLONG   = 3'd4;

  // query handed from front to back
  typedef struct packed {
    logic valid;
    logic ovf;
  } job_ctl_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } back_stat_t;

  function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [31:0] v);
    return v[OUT_IDX_W-1:0];
  endfunction

endpackage

### src/oedm_front.sv
module oedm_front #(
  parameter int DICT_DEPTH   = oedm_pkg::DEF_DICT_DEPTH,
  parameter int MAX_WORD_LEN = oedm_pkg::DEF_MAX_WORD_LEN
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_req_type,
  input  logic [7:0]                           in_char_code,
  input  logic                                 in_word_end,
  input  oedm_pkg::back_stat_t                 back_stat,
  output oedm_pkg::job_ctl_t                   job_ctl,
  output logic [MAX_WORD_LEN*8-1:0]            job_chars,
  output logic [$clog2(MAX_WORD_LEN+1)-1:0]    job_len,
  output logic [$clog2(DICT_DEPTH+1)-1:0]      job_cnt,
  output logic                                 wr_en,
  output logic [(DICT_DEPTH > 1 ? $clog2(DICT_DEPTH) : 1)-1:0] wr_addr,
  output logic [MAX_WORD_LEN*8+$clog2(MAX_WORD_LEN+1)-1:0]     wr_row
);
  import oedm_pkg::*;

  localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
  localparam int CNT_W  = $clog2(DICT_DEPTH + 1);
  localparam int IDX_W  = DICT_DEPTH > 1 ? $clog2(DICT_DEPTH) : 1;
  localparam int WIDX_W = $clog2(MAX_WORD_LEN);
  localparam int CH_W   = MAX_WORD_LEN * 8;

  logic [7:0]       wbuf_r [MAX_WORD_LEN];
  logic [LEN_W-1:0] wlen_r, wlen_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             job_v_r, job_v_nxt;
  logic             job_ovf_r, job_ovf_nxt;
  logic [CH_W-1:0]  job_chars_r, job_chars_nxt;
  logic [LEN_W-1:0] job_len_r, job_len_nxt;
  logic [CNT_W-1:0] job_cnt_r, job_cnt_nxt;

  logic             accept;
  logic             room;
  logic [CH_W-1:0]  word_nxt;
  logic [LEN_W-1:0] len_new;
  logic             ovf_new;
  logic             buf_we;

  assign busy   = job_v_r | back_stat.busy;
  assign accept = start & ~busy;
  assign room   = wlen_r < LEN_W'(MAX_WORD_LEN);

  always_comb begin
    for (int i = 0; i < MAX_WORD_LEN; i++) begin
      word_nxt[i*8 +: 8] = (room && wlen_r == LEN_W'(i)) ? in_char_code : wbuf_r[i];
    end
  end

  assign len_new = room ? wlen_r + LEN_W'(1) : wlen_r;
  assign ovf_new = ovf_r | ~room;

  always_comb begin
    wlen_nxt      = wlen_r;
    ovf_nxt       = ovf_r;
    count_nxt     = count_r;
    job_v_nxt     = job_v_r & ~back_stat.pop;
    job_ovf_nxt   = job_ovf_r;
    job_chars_nxt = job_chars_r;
    job_len_nxt   = job_len_r;
    job_cnt_nxt   = job_cnt_r;
    buf_we        = 1'b0;
    wr_en         = 1'b0;
    if (accept) begin
      unique case (in_req_type)
        REQ_DICT, REQ_QUERY: begin
          buf_we   = room;
          wlen_nxt = len_new;
          ovf_nxt  = ovf_new;
          if (in_word_end) begin
            wlen_nxt = '0;
            ovf_nxt  = 1'b0;
            if (in_req_type == REQ_DICT) begin
              if (!ovf_new && count_r != CNT_W'(DICT_DEPTH)) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end else begin
              job_v_nxt     = 1'b1;
              job_ovf_nxt   = ovf_new;
              job_chars_nxt = word_nxt;
              job_len_nxt   = len_new;
              job_cnt_nxt   = count_r;
            end
          end
        end
        REQ_CLEAR: begin
          count_nxt = '0;
          wlen_nxt  = '0;
          ovf_nxt   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign wr_addr = count_r[IDX_W-1:0];
  assign wr_row  = {len_new, word_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= '0;
      ovf_r   <= 1'b0;
      count_r <= '0;
      job_v_r <= 1'b0;
    end else begin
      wlen_r  <= wlen_nxt;
      ovf_r   <= ovf_nxt;
      count_r <= count_nxt;
      job_v_r <= job_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      wbuf_r[wlen_r[WIDX_W-1:0]] <= in_char_code;
    end
    job_ovf_r   <= job_ovf_nxt;
    job_chars_r <= job_chars_nxt;
    job_len_r   <= job_len_nxt;
    job_cnt_r   <= job_cnt_nxt;
  end

  assign job_ctl   = {job_v_r, job_ovf_r};
  assign job_chars = job_chars_r;
  assign job_len   = job_len_r;
  assign job_cnt   = job_cnt_r;

endmodule

### src/oedm_back.sv
module oedm_back #(
  parameter int DICT_DEPTH     = oedm_pkg::DEF_DICT_DEPTH,
  parameter int MAX_WORD_LEN   = oedm_pkg::DEF_MAX_WORD_LEN,
  parameter int MAX_CANDIDATES = oedm_pkg::DEF_MAX_CANDIDATES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  oedm_pkg::job_ctl_t                   job_ctl,
  input  logic [MAX_WORD_LEN*8-1:0]            job_chars,
  input  logic [$clog2(MAX_WORD_LEN+1)-1:0]    job_len,
  input  logic [$clog2(DICT_DEPTH+1)-1:0]      job_cnt,
  output oedm_pkg::back_stat_t                 back_stat,
  input  logic                                 wr_en,
  input  logic [(DICT_DEPTH > 1 ? $clog2(DICT_DEPTH) : 1)-1:0] wr_addr,
  input  logic [MAX_WORD_LEN*8+$clog2(MAX_WORD_LEN+1)-1:0]     wr_row,
  output logic                                 out_valid,
  output logic [2:0]                           out_verdict,
  output logic [oedm_pkg::OUT_IDX_W-1:0]       out_entry_index,
  output logic                                 out_last_result
);
  import oedm_pkg::*;

  localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
  localparam int CNT_W  = $clog2(DICT_DEPTH + 1);
  localparam int IDX_W  = DICT_DEPTH > 1 ? $clog2(DICT_DEPTH) : 1;
  localparam int CH_W   = MAX_WORD_LEN * 8;
  localparam int ROW_W  = CH_W + LEN_W;
  localparam int CIDX_W = MAX_CANDIDATES > 1 ? $clog2(MAX_CANDIDATES) : 1;
  localparam int FND_W  = $clog2(MAX_CANDIDATES + 2);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_EMIT  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_TRUNC = 3'd4;

  logic [ROW_W-1:0]     dmem [DICT_DEPTH];
  logic [OUT_IDX_W-1:0] cmem [MAX_CANDIDATES];

  logic [2:0]           state_r, state_nxt;
  logic [CH_W-1:0]      q_chars_r;
  logic [LEN_W-1:0]     q_len_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 iss_r, iss_nxt;
  logic                 rd_v_r, rd_v_nxt;
  logic                 rd_last_r, rd_last_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic [ROW_W-1:0]     row_q_r;
  logic [FND_W-1:0]     found_r, found_nxt;
  logic [FND_W-1:0]     em_n_r, em_n_nxt;
  logic                 em_v_r, em_v_nxt;
  logic                 em_last_r, em_last_nxt;
  logic [OUT_IDX_W-1:0] cm_q_r;
  logic                 out_v_r, out_v_nxt;
  logic [2:0]           out_verdict_r, out_verdict_nxt;
  logic [OUT_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 rd_en;
  logic                 cm_we, cm_re;
  logic [CIDX_W-1:0]    cm_raddr;
  logic                 q_load;
  logic                 trunc;
  logic [FND_W-1:0]     emit_cnt;

  // entry classification on the registered row
  logic [LEN_W-1:0]       d_len;
  logic [CH_W-1:0]        d_chars;
  logic [MAX_WORD_LEN-1:0] mism;
  logic                   same_len, long_d, long_q;
  logic [CH_W-1:0]        s_w, l_w;
  logic [LEN_W-1:0]       sl;
  logic [MAX_WORD_LEN-1:0] eqa, eqb;
  logic [MAX_WORD_LEN:0]  pre, suf;
  logic                   is_exact, is_cand;

  assign d_len   = row_q_r[ROW_W-1 -: LEN_W];
  assign d_chars = row_q_r[CH_W-1:0];

  always_comb begin
    same_len = d_len == q_len_r;
    long_d   = ({1'b0, d_len} == {1'b0, q_len_r} + (LEN_W+1)'(1));
    long_q   = ({1'b0, q_len_r} == {1'b0, d_len} + (LEN_W+1)'(1));
    for (int i = 0; i < MAX_WORD_LEN; i++) begin
      mism[i] = (d_chars[i*8 +: 8] != q_chars_r[i*8 +: 8]) && (LEN_W'(i) < q_len_r);
    end
    l_w = long_d ? d_chars : q_chars_r;
    s_w = long_d ? q_chars_r : d_chars;
    sl  = long_d ? q_len_r : d_len;
    for (int i = 0; i < MAX_WORD_LEN; i++) begin
      eqa[i] = (s_w[i*8 +: 8] == l_w[i*8 +: 8]) || (LEN_W'(i) >= sl);
    end
    for (int i = 0; i < MAX_WORD_LEN - 1; i++) begin
      eqb[i] = (s_w[i*8 +: 8] == l_w[(i+1)*8 +: 8]) || (LEN_W'(i) >= sl);
    end
    eqb[MAX_WORD_LEN-1] = 1'b1;
    pre[0] = 1'b1;
    for (int k = 0; k < MAX_WORD_LEN; k++) begin
      pre[k+1] = pre[k] & eqa[k];
    end
    suf[MAX_WORD_LEN] = 1'b1;
    for (int k = MAX_WORD_LEN - 1; k >= 0; k--) begin
      suf[k] = suf[k+1] & eqb[k];
    end
    is_exact = same_len && (mism == '0);
    is_cand  = (same_len && $onehot(mism)) || ((long_d || long_q) && |(pre & suf));
  end

  assign trunc    = found_r > FND_W'(MAX_CANDIDATES);
  assign emit_cnt = trunc ? FND_W'(MAX_CANDIDATES) : found_r;
  assign cm_raddr = em_n_r[CIDX_W-1:0];

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    iss_nxt         = iss_r;
    rd_v_nxt        = 1'b0;
    rd_last_nxt     = rd_last_r;
    rd_idx_nxt      = rd_idx_r;
    found_nxt       = found_r;
    em_n_nxt        = em_n_r;
    em_v_nxt        = 1'b0;
    em_last_nxt     = em_last_r;
    out_v_nxt       = 1'b0;
    out_verdict_nxt = VERDICT_NONE;
    out_idx_nxt     = '0;
    out_last_nxt    = 1'b0;
    rd_en           = 1'b0;
    cm_we           = 1'b0;
    cm_re           = 1'b0;
    q_load          = 1'b0;
    back_stat.pop   = 1'b0;
    back_stat.busy  = state_r != ST_IDLE;

    if (em_v_r) begin
      out_v_nxt       = 1'b1;
      out_verdict_nxt = VERDICT_CANDIDATE;
      out_idx_nxt     = cm_q_r;
      out_last_nxt    = em_last_r;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (job_ctl.valid) begin
          back_stat.pop = 1'b1;
          q_load        = 1'b1;
          if (job_ctl.ovf) begin
            out_v_nxt       = 1'b1;
            out_verdict_nxt = VERDICT_TOOLONG;
            out_last_nxt    = 1'b1;
          end else if (job_cnt == '0) begin
            out_v_nxt       = 1'b1;
            out_verdict_nxt = VERDICT_NONE;
            out_last_nxt    = 1'b1;
          end else begin
            state_nxt = ST_SCAN;
            cnt_nxt   = job_cnt;
            idx_nxt   = '0;
            iss_nxt   = 1'b1;
            found_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        if (iss_r) begin
          rd_en       = 1'b1;
          rd_v_nxt    = 1'b1;
          rd_idx_nxt  = idx_r;
          rd_last_nxt = CNT_W'(idx_r) + CNT_W'(1) == cnt_r;
          idx_nxt     = idx_r + IDX_W'(1);
          iss_nxt     = ~rd_last_nxt;
        end
        if (rd_v_r) begin
          if (is_exact) begin
            out_v_nxt       = 1'b1;
            out_verdict_nxt = VERDICT_CORRECT;
            out_idx_nxt     = to_out_idx(32'(rd_idx_r));
            out_last_nxt    = 1'b1;
            state_nxt       = ST_IDLE;
            iss_nxt         = 1'b0;
            rd_v_nxt        = 1'b0;
          end else begin
            if (is_cand) begin
              cm_we = found_r < FND_W'(MAX_CANDIDATES);
              if (!trunc) begin
                found_nxt = found_r + FND_W'(1);
              end
            end
            if (rd_last_r) begin
              if (found_nxt == '0) begin
                out_v_nxt       = 1'b1;
                out_verdict_nxt = VERDICT_NONE;
                out_last_nxt    = 1'b1;
                state_nxt       = ST_IDLE;
              end else begin
                state_nxt = ST_EMIT;
                em_n_nxt  = '0;
              end
            end
          end
        end
      end
      ST_EMIT: begin
        cm_re       = 1'b1;
        em_v_nxt    = 1'b1;
        em_last_nxt = !trunc && (em_n_r + FND_W'(1) == found_r);
        em_n_nxt    = em_n_r + FND_W'(1);
        if (em_n_r + FND_W'(1) == emit_cnt) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = trunc ? ST_TRUNC : ST_IDLE;
      end
      ST_TRUNC: begin
        out_v_nxt       = 1'b1;
        out_verdict_nxt = VERDICT_TRUNC;
        out_last_nxt    = 1'b1;
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iss_r   <= 1'b0;
      rd_v_r  <= 1'b0;
      em_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      found_r <= '0;
      em_n_r  <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      iss_r   <= iss_nxt;
      rd_v_r  <= rd_v_nxt;
      em_v_r  <= em_v_nxt;
      out_v_r <= out_v_nxt;
      found_r <= found_nxt;
      em_n_r  <= em_n_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_load) begin
      q_chars_r <= job_chars;
      q_len_r   <= job_len;
    end
    rd_last_r     <= rd_last_nxt;
    rd_idx_r      <= rd_idx_nxt;
    em_last_r     <= em_last_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_idx_r     <= out_idx_nxt;
    out_last_r    <= out_last_nxt;
  end

  // dictionary rows: one write port from the front, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dmem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      row_q_r <= dmem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cm_we) begin
      cmem[found_r[CIDX_W-1:0]] <= to_out_idx(32'(rd_idx_r));
    end
    if (cm_re) begin
      cm_q_r <= cmem[cm_raddr];
    end
  end

  assign out_valid       = out_v_r;
  assign out_verdict     = out_verdict_r;
  assign out_entry_index = out_idx_r;
  assign out_last_result = out_last_r;

endmodule

### src/one_edit_dictionary_matcher.sv
// channel   | ports                                              | handshake
// input     | in_req_type, in_char_code, in_word_end             | start & !busy
// result    | out_verdict, out_entry_index, out_last_result      | out_valid, one cycle
//
// a dictionary character, clear or non-final query character does not raise busy
// a query end starts a scan of one row per cycle, which stops early on an exact match;
// candidates are then listed, followed by a truncation result when there are too many,
// and an over-long query or an empty table gets its result without a scan
// reset is synchronous and clears the table count, partial word and engine state
// busy stays high while a query is queued, scanned or listed; results cannot be stalled
module one_edit_dictionary_matcher #(
  parameter int DICT_DEPTH     = oedm_pkg::DEF_DICT_DEPTH,
  parameter int MAX_WORD_LEN   = oedm_pkg::DEF_MAX_WORD_LEN,
  parameter int MAX_CANDIDATES = oedm_pkg::DEF_MAX_CANDIDATES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_req_type,
  input  logic [7:0]                     in_char_code,
  input  logic                           in_word_end,
  output logic                           out_valid,
  output logic [2:0]                     out_verdict,
  output logic [oedm_pkg::OUT_IDX_W-1:0] out_entry_index,
  output logic                           out_last_result
);
  import oedm_pkg::*;

  localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
  localparam int CNT_W = $clog2(DICT_DEPTH + 1);
  localparam int IDX_W = DICT_DEPTH > 1 ? $clog2(DICT_DEPTH) : 1;
  localparam int ROW_W = MAX_WORD_LEN * 8 + LEN_W;

  job_ctl_t                  job_ctl;
  back_stat_t                back_stat;
  logic [MAX_WORD_LEN*8-1:0] job_chars;
  logic [LEN_W-1:0]          job_len;
  logic [CNT_W-1:0]          job_cnt;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic [ROW_W-1:0]          wr_row;

  oedm_front #(
    .DICT_DEPTH  (DICT_DEPTH),
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_char_code(in_char_code),
    .in_word_end (in_word_end),
    .back_stat   (back_stat),
    .job_ctl     (job_ctl),
    .job_chars   (job_chars),
    .job_len     (job_len),
    .job_cnt     (job_cnt),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_row      (wr_row)
  );

  oedm_back #(
    .DICT_DEPTH    (DICT_DEPTH),
    .MAX_WORD_LEN  (MAX_WORD_LEN),
    .MAX_CANDIDATES(MAX_CANDIDATES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_ctl        (job_ctl),
    .job_chars      (job_chars),
    .job_len        (job_len),
    .job_cnt        (job_cnt),
    .back_stat      (back_stat),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_row         (wr_row),
    .out_valid      (out_valid),
    .out_verdict    (out_verdict),
    .out_entry_index(out_entry_index),
    .out_last_result(out_last_result)
  );

endmodule

### src/oedm_checker.sv
module oedm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [1:0]                     in_req_type,
  input logic                           out_valid,
  input logic [2:0]                     out_verdict,
  input logic [oedm_pkg::OUT_IDX_W-1:0] out_entry_index,
  input logic                           out_last_result
);
  import oedm_pkg::*;

  // only candidates can be followed by more results
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict != VERDICT_CANDIDATE |-> out_last_result)
    else $error("non-candidate result without last flag");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict != VERDICT_CANDIDATE && out_verdict != VERDICT_CORRECT
      |-> out_entry_index == '0)
    else $error("index set on a result without an entry");

  // a candidate list comes out without gaps
  a_list_dense: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |=> out_valid)
    else $error("gap inside a result list");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type == REQ_CLEAR |=> !out_valid)
    else $error("result after a clear");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

endmodule

bind one_edit_dictionary_matcher oedm_checker u_oedm_checker (.*);
